// ----- design/kgcs_pkg.sv -----
// Package: shared types and constants for the 3x3 Cholesky gain solver.
`timescale 1ns / 1ps

package kgcs_pkg;

    localparam int W = 32;

    // Solve steps; each step writes its result into ctx_t.v[step]
    localparam int STEP_Y0 = 0;
    localparam int STEP_Y1 = 1;
    localparam int STEP_Y2 = 2;
    localparam int STEP_X2 = 3;
    localparam int STEP_X1 = 4;
    localparam int STEP_X0 = 5;
    localparam int N_STEPS = 6;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIAG = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic signed [W-1:0] l_00;
        logic signed [W-1:0] l_10;
        logic signed [W-1:0] l_11;
        logic signed [W-1:0] l_20;
        logic signed [W-1:0] l_21;
        logic signed [W-1:0] l_22;
        logic signed [W-1:0] cov_row_0;
        logic signed [W-1:0] cov_row_1;
        logic signed [W-1:0] cov_row_2;
    } req_t;

    typedef struct packed {
        logic signed [W-1:0] gain_0;
        logic signed [W-1:0] gain_1;
        logic signed [W-1:0] gain_2;
        logic [1:0]          status;
    } rsp_t;

    // Item context carried down the pipe
    typedef struct packed {
        req_t                         req;
        logic [N_STEPS-1:0][W-1:0]    v;
        logic                         err;
        logic                         sat;
    } ctx_t;

endpackage

// ----- design/kalman_gain_cholesky_solve_3x3.sv -----
// Top level: six chained substitution steps and the output register.
//
//  channel | signals                       | direction
//  req     | req_valid, req_stall, req_data | in (req_stall out)
//  rsp     | rsp_valid, rsp_stall, rsp_data | out (rsp_stall in)
//
// One row per cycle while the output register is not held; each step registers product,
// accumulate, magnitude, 32 one-bit divide stages and clamp, then the output register.
// All stages move together; a stalled full output register holds the pipe.
// Reset clears the valid bits only.
`timescale 1ns / 1ps

module kalman_gain_cholesky_solve_3x3 #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  kgcs_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output kgcs_pkg::rsp_t  rsp_data
);

    localparam int NS = kgcs_pkg::N_STEPS;

    logic           en;
    logic           vld_c  [0:NS];
    kgcs_pkg::ctx_t ctx_c  [0:NS];

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    always_comb
    begin
        ctx_c[0]     = '0;
        ctx_c[0].req = req_data;
        ctx_c[0].err = (req_data.l_00 <= 0) || (req_data.l_11 <= 0)
                       || (req_data.l_22 <= 0);
        vld_c[0]     = req_valid;
    end

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_step
            kgcs_solve #(
                .STEP      (s),
                .FRAC_BITS (FRAC_BITS)
            ) u_solve (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .in_vld  (vld_c[s]),
                .in_ctx  (ctx_c[s]),
                .out_vld (vld_c[s+1]),
                .out_ctx (ctx_c[s+1])
            );
        end
    endgenerate

    logic           rsp_valid_reg;
    kgcs_pkg::rsp_t rsp_data_reg;
    kgcs_pkg::rsp_t rsp_data_next;

    always_comb
    begin
        if (ctx_c[NS].err)
        begin
            rsp_data_next.gain_0 = '0;
            rsp_data_next.gain_1 = '0;
            rsp_data_next.gain_2 = '0;
            rsp_data_next.status = kgcs_pkg::STATUS_DIAG;
        end
        else
        begin
            rsp_data_next.gain_0 = ctx_c[NS].v[kgcs_pkg::STEP_X0];
            rsp_data_next.gain_1 = ctx_c[NS].v[kgcs_pkg::STEP_X1];
            rsp_data_next.gain_2 = ctx_c[NS].v[kgcs_pkg::STEP_X2];
            rsp_data_next.status = ctx_c[NS].sat ? kgcs_pkg::STATUS_SAT
                                                 : kgcs_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
            rsp_valid_reg <= vld_c[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_diag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == kgcs_pkg::STATUS_DIAG
        |-> rsp_data.gain_0 == '0 && rsp_data.gain_1 == '0 && rsp_data.gain_2 == '0)
        else $error("error result with nonzero gain");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("input stall does not follow held output");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status != 2'd3)
        else $error("undefined status code");

endmodule

// ----- design/kgcs_solve.sv -----
// One substitution step: products, accumulate, magnitude, 32-stage restoring divide, clamp.
`timescale 1ns / 1ps

module kgcs_solve #(
    parameter int STEP      = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  kgcs_pkg::ctx_t in_ctx,
    output logic          out_vld,
    output kgcs_pkg::ctx_t out_ctx
);

    localparam int W  = kgcs_pkg::W;
    localparam int AW = 66;

    logic signed [W-1:0] head;
    logic signed [W-1:0] c1;
    logic signed [W-1:0] v1;
    logic signed [W-1:0] c2;
    logic signed [W-1:0] v2;
    logic signed [W-1:0] diag;
    logic                use1;
    logic                use2;

    always_comb
    begin
        head = '0;
        c1   = '0;
        v1   = '0;
        c2   = '0;
        v2   = '0;
        diag = '0;
        use1 = 1'b0;
        use2 = 1'b0;
        unique case (STEP)
            kgcs_pkg::STEP_Y0:
            begin
                head = in_ctx.req.cov_row_0;
                diag = in_ctx.req.l_00;
            end
            kgcs_pkg::STEP_Y1:
            begin
                head = in_ctx.req.cov_row_1;
                c1   = in_ctx.req.l_10;
                v1   = in_ctx.v[kgcs_pkg::STEP_Y0];
                use1 = 1'b1;
                diag = in_ctx.req.l_11;
            end
            kgcs_pkg::STEP_Y2:
            begin
                head = in_ctx.req.cov_row_2;
                c1   = in_ctx.req.l_20;
                v1   = in_ctx.v[kgcs_pkg::STEP_Y0];
                c2   = in_ctx.req.l_21;
                v2   = in_ctx.v[kgcs_pkg::STEP_Y1];
                use1 = 1'b1;
                use2 = 1'b1;
                diag = in_ctx.req.l_22;
            end
            kgcs_pkg::STEP_X2:
            begin
                head = in_ctx.v[kgcs_pkg::STEP_Y2];
                diag = in_ctx.req.l_22;
            end
            kgcs_pkg::STEP_X1:
            begin
                head = in_ctx.v[kgcs_pkg::STEP_Y1];
                c1   = in_ctx.req.l_21;
                v1   = in_ctx.v[kgcs_pkg::STEP_X2];
                use1 = 1'b1;
                diag = in_ctx.req.l_11;
            end
            default:
            begin
                head = in_ctx.v[kgcs_pkg::STEP_Y0];
                c1   = in_ctx.req.l_10;
                v1   = in_ctx.v[kgcs_pkg::STEP_X1];
                c2   = in_ctx.req.l_20;
                v2   = in_ctx.v[kgcs_pkg::STEP_X2];
                use1 = 1'b1;
                use2 = 1'b1;
                diag = in_ctx.req.l_00;
            end
        endcase
    end

    // Stage M: products
    logic signed [2*W-1:0] p1_reg;
    logic signed [2*W-1:0] p2_reg;
    logic signed [W-1:0]   head_reg;
    logic [W-1:0]          dm_reg;
    kgcs_pkg::ctx_t        ctxm_reg;
    logic                  vldm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldm_reg <= 1'b0;
        else if (en)
            vldm_reg <= in_vld;
    end

    // signed zero keeps the products signed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= use1 ? c1 * v1 : $signed({2*W{1'b0}});
            p2_reg   <= use2 ? c2 * v2 : $signed({2*W{1'b0}});
            head_reg <= head;
            dm_reg   <= diag;
            ctxm_reg <= in_ctx;
        end
    end

    // Stage A: exact sum
    logic signed [AW-1:0] acc_reg;
    logic [W-1:0]         da_reg;
    kgcs_pkg::ctx_t       ctxa_reg;
    logic                 vlda_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vlda_reg <= 1'b0;
        else if (en)
            vlda_reg <= vldm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= (AW'(head_reg) <<< FRAC_BITS) - AW'(p1_reg) - AW'(p2_reg);
            da_reg   <= dm_reg;
            ctxa_reg <= ctxm_reg;
        end
    end

    // Magnitude and early overflow check
    logic [AW-1:0] mag;
    logic          sat_e;

    always_comb
    begin
        mag   = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        sat_e = mag >= {2'b00, da_reg, 32'h0};
    end

    // Divider pipe: index 0 is the output of the magnitude stage
    logic [W-1:0]   r_s    [0:W];
    logic [W-1:0]   q_s    [0:W];
    logic [W-1:0]   lo_s   [0:W];
    logic [W-1:0]   d_s    [0:W];
    logic           neg_s  [0:W];
    logic           sat_s  [0:W];
    kgcs_pkg::ctx_t ctx_s  [0:W];
    logic           vld_s  [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s[0] <= 1'b0;
        else if (en)
            vld_s[0] <= vlda_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_s[0]   <= mag[2*W-1:W];
            q_s[0]   <= '0;
            lo_s[0]  <= mag[W-1:0];
            d_s[0]   <= da_reg;
            neg_s[0] <= acc_reg[AW-1];
            sat_s[0] <= sat_e;
            ctx_s[0] <= ctxa_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_div
            logic [W:0] t;
            logic       ge;

            always_comb
            begin
                t  = {r_s[k], lo_s[k][W-1-k]};
                ge = t >= {1'b0, d_s[k]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_s[k+1] <= 1'b0;
                else if (en)
                    vld_s[k+1] <= vld_s[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_s[k+1]   <= ge ? W'(t - {1'b0, d_s[k]}) : t[W-1:0];
                    q_s[k+1]   <= {q_s[k][W-2:0], ge};
                    lo_s[k+1]  <= lo_s[k];
                    d_s[k+1]   <= d_s[k];
                    neg_s[k+1] <= neg_s[k];
                    sat_s[k+1] <= sat_s[k];
                    ctx_s[k+1] <= ctx_s[k];
                end
            end
        end
    endgenerate

    // Stage F: sign and clamp
    logic [W-1:0]   q;
    logic [W-1:0]   res;
    logic           sat_f;
    kgcs_pkg::ctx_t ctx_f;

    always_comb
    begin
        q = q_s[W];
        if (sat_s[W])
        begin
            sat_f = 1'b1;
            res   = neg_s[W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (neg_s[W])
        begin
            sat_f = q > 32'h8000_0000;
            res   = sat_f ? 32'h8000_0000 : W'(32'h0 - q);
        end
        else
        begin
            sat_f = q[W-1];
            res   = sat_f ? 32'h7FFF_FFFF : q;
        end
        ctx_f          = ctx_s[W];
        ctx_f.v[STEP]  = res;
        ctx_f.sat      = ctx_s[W].sat | sat_f;
    end

    logic           vldf_reg;
    kgcs_pkg::ctx_t ctxf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldf_reg <= 1'b0;
        else if (en)
            vldf_reg <= vld_s[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ctxf_reg <= ctx_f;
    end

    assign out_vld = vldf_reg;
    assign out_ctx = ctxf_reg;

endmodule

// ----- tb/kalman_gain_cholesky_solve_3x3_test.sv -----
// Testbench for the 3x3 Cholesky gain row solver: directed and random traffic checked by a scoreboard.
`timescale 1ns / 1ps

module kalman_gain_cholesky_solve_3x3_test;

    localparam int FRAC = 16;
    localparam int NUM_RANDOM = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 250;
    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    class gain_board;
        kgcs_pkg::rsp_t expected_rows[$];
        int   failures;

        // one substitution step: (head * 2^F - c1*v1 - c2*v2) / diag, truncated and clamped
        static function logic signed [31:0] subst_step(logic signed [31:0] head,
                logic signed [31:0] c1, logic signed [31:0] v1,
                logic signed [31:0] c2, logic signed [31:0] v2,
                logic signed [31:0] diag, inout bit sat);
            logic signed [127:0] acc, a1, b1, a2, b2, d, q;
            acc = head;
            a1 = c1;
            b1 = v1;
            a2 = c2;
            b2 = v2;
            d = diag;
            acc = (acc <<< FRAC) - a1 * b1 - a2 * b2;
            q = acc / d;
            if (q > 128'sh7fffffff)
            begin
                sat = 1;
                return MAX32;
            end
            if (q < -128'sh80000000)
            begin
                sat = 1;
                return MIN32;
            end
            return q[31:0];
        endfunction

        static function kgcs_pkg::rsp_t solve_row(kgcs_pkg::req_t r);
            kgcs_pkg::rsp_t o;
            bit sat;
            logic signed [31:0] y0, y1, y2, x0, x1, x2;
            sat = 0;
            if (r.l_00 <= 0 || r.l_11 <= 0 || r.l_22 <= 0)
            begin
                o.gain_0 = '0;
                o.gain_1 = '0;
                o.gain_2 = '0;
                o.status = kgcs_pkg::STATUS_DIAG;
                return o;
            end
            y0 = subst_step(r.cov_row_0, 0, 0, 0, 0, r.l_00, sat);
            y1 = subst_step(r.cov_row_1, r.l_10, y0, 0, 0, r.l_11, sat);
            y2 = subst_step(r.cov_row_2, r.l_20, y0, r.l_21, y1, r.l_22, sat);
            x2 = subst_step(y2, 0, 0, 0, 0, r.l_22, sat);
            x1 = subst_step(y1, r.l_21, x2, 0, 0, r.l_11, sat);
            x0 = subst_step(y0, r.l_10, x1, r.l_20, x2, r.l_00, sat);
            o.gain_0 = x0;
            o.gain_1 = x1;
            o.gain_2 = x2;
            o.status = sat ? kgcs_pkg::STATUS_SAT : kgcs_pkg::STATUS_OK;
            return o;
        endfunction

        function void note_request(kgcs_pkg::req_t r);
            expected_rows.push_back(solve_row(r));
        endfunction

        function void check_result(kgcs_pkg::rsp_t got);
            kgcs_pkg::rsp_t want;
            if (expected_rows.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result transfer: %p", got);
                return;
            end
            want = expected_rows.pop_front();
            if (got.gain_0 !== want.gain_0 || got.gain_1 !== want.gain_1 ||
                got.gain_2 !== want.gain_2 || got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display("gain mismatch: expected %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                             want.gain_0, want.gain_1, want.gain_2, want.status,
                             got.gain_0, got.gain_1, got.gain_2, got.status);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_stall;
    kgcs_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    kgcs_pkg::rsp_t rsp_data;

    gain_board board = new();
    bit no_idle = 0;
    int cycles = 0;

    kalman_gain_cholesky_solve_3x3 #(.FRAC_BITS(FRAC)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            board.note_request(req_data);
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp_data);
    end

    // result side: random hold-off before each transfer
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            k = no_idle ? 0 : $urandom_range(0, 3);
            if (k > 0)
            begin
                rsp_stall <= 1;
                repeat (k) @(posedge clk);
                rsp_stall <= 0;
            end
            do @(negedge clk); while (!rsp_valid);
            @(posedge clk);
        end
    end

    // called at a rising edge; returns at the edge where the transfer happens
    task automatic send_row(kgcs_pkg::req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1;
        req_data <= r;
        do @(negedge clk); while (req_stall);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_diag();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(1, 255);
            2: return $urandom_range(1, 32'h7fffffff);
            default: return $urandom_range(1 << 12, 1 << 20);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic kgcs_pkg::req_t make_row(logic signed [31:0] d0,
                                                logic signed [31:0] d1,
                                                logic signed [31:0] d2,
                                                logic signed [31:0] off,
                                                logic signed [31:0] b);
        kgcs_pkg::req_t r;
        r.l_00 = d0;
        r.l_11 = d1;
        r.l_22 = d2;
        r.l_10 = off;
        r.l_20 = off;
        r.l_21 = off;
        r.cov_row_0 = b;
        r.cov_row_1 = b;
        r.cov_row_2 = b;
        return r;
    endfunction

    initial
    begin
        kgcs_pkg::req_t r;
        int waited;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity, bad diagonals, extremes, saturation
        send_row(make_row(32'sh10000, 32'sh10000, 32'sh10000, 0, 32'sh10000));
        send_row(make_row(0, 32'sh10000, 32'sh10000, 0, 32'sh10000));
        send_row(make_row(32'sh10000, 0, 32'sh10000, 0, 32'sh10000));
        send_row(make_row(32'sh10000, 32'sh10000, 0, 0, 32'sh10000));
        send_row(make_row(MIN32, 32'sh10000, 32'sh10000, 5, 7));
        send_row(make_row(32'sh10000, -1, 32'sh10000, 5, 7));
        send_row(make_row(32'sh10000, 32'sh10000, MIN32, 5, 7));
        send_row(make_row(1, 1, 1, 0, MAX32));
        send_row(make_row(1, 1, 1, 0, MIN32));
        send_row(make_row(MAX32, MAX32, MAX32, MAX32, MAX32));
        send_row(make_row(MAX32, MAX32, MAX32, MIN32, MIN32));
        send_row(make_row(1, 1, 1, MIN32, MIN32));
        send_row(make_row(32'sh10000, 32'sh10000, 32'sh10000, 32'sh8000, -32'sh8000));
        send_row(make_row(32'sh20000, 32'sh18000, 32'sh30000, -32'sh4000, 32'sh12345));
        // quotient exactly -2^31 stays unclamped
        send_row(make_row(32'sh10000, 32'sh10000, 32'sh10000, 0, MIN32));
        send_row(make_row(MAX32, 1, MAX32, -1, 1));

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 200 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            r.l_00 = pick_diag();
            r.l_11 = pick_diag();
            r.l_22 = pick_diag();
            r.l_10 = pick_value();
            r.l_20 = pick_value();
            r.l_21 = pick_value();
            r.cov_row_0 = pick_value();
            r.cov_row_1 = pick_value();
            r.cov_row_2 = pick_value();
            send_row(r);
        end
        req_valid <= 0;
        no_idle = 0;

        waited = 0;
        while (board.expected_rows.size() != 0 && waited < CYCLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.expected_rows.size() != 0)
            board.failures++;
        if (board.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
